// ===== src/dagac_pkg.sv =====
// Shared types and constants for the door access and gas alarm controller.
// No dependencies; the interfaces and the top level use it by scoped names.
package dagac_pkg;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_GAS_HIGH    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAS_LOW     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WRONG_LIMIT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WRONG_MS    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CLOSE_DELAY = 3'd4;

    // Configuration reset values.
    localparam logic [11:0] GAS_HIGH_RST    = 12'd2000;
    localparam logic [11:0] GAS_LOW_RST     = 12'd1500;
    localparam logic [3:0]  WRONG_LIMIT_RST = 4'd3;
    localparam logic [15:0] WRONG_MS_RST    = 16'd3000;
    localparam logic [19:0] CLOSE_DELAY_RST = 20'd5000;

    // App door command codes.
    localparam logic [1:0] APP_CLOSE = 2'd1;
    localparam logic [1:0] APP_OPEN  = 2'd2;

    // Chirp timing in milliseconds.
    localparam logic [31:0] CHIRP_SINGLE_MS = 32'd150;
    localparam logic [31:0] CHIRP_ON_MS     = 32'd80;
    localparam logic [31:0] CHIRP_PERIOD_MS = 32'd160;
    localparam logic [31:0] CHIRP_DOUBLE_MS = 32'd320;

    // Miss counter ceiling.
    localparam logic [3:0] MISS_MAX = 4'd15;

    // One control pass word.
    typedef struct packed {
        logic [31:0] now_ms;
        logic [11:0] gas_level;
        logic        card_event;
        logic        card_ok;
        logic        door_button;
        logic [1:0]  app_door;
    } pass_t;

    // One result word.
    typedef struct packed {
        logic door_open;
        logic door_sync;
        logic buzzer_on;
        logic alert_led_on;
        logic wrong_card_on;
        logic gas_alarm_on;
    } result_t;

endpackage

// ===== src/dagac_if.sv =====
// Valid/ready channel interfaces for the pass and result words.
// Depends on dagac_pkg for the payload types.
interface dagac_pass_if;
    logic              valid;
    logic              ready;
    dagac_pkg::pass_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dagac_result_if;
    logic               valid;
    logic               ready;
    dagac_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/door_access_gas_alarm_controller.sv =====
// Door access and gas alarm controller, top level.
// Depends on dagac_pkg and the channel interfaces in dagac_if.sv.
//
// Usage: each word on the pass channel is one control pass carrying a
// millisecond timestamp, a gas reading, a card scan, a button press and an
// app door command. For every pass word exactly one word appears on the
// result channel, in order, with the door, buzzer and alarm outputs.
// A pass word is first captured in an input register; the update logic then
// reads it with the controller state, and at the edge that moves it on the
// new state and the result word are registered together. One pass word is
// accepted every cycle while the result receiver does not stall; the state
// loop closes through compare and add logic alone.
// When the result receiver stalls, the result register holds its word and
// the input register holds one more pass; pass.ready drops only when both
// are full. Reset clears all controller state (door closed, no alarms, no
// chirp, no pending close), empties both registers and restores the
// configuration defaults. Configuration is written through cfg_wr_en,
// cfg_index and cfg_data while no pass is in flight; the block does not
// enforce this, the user must. Unknown indexes are ignored.
module door_access_gas_alarm_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    dagac_pass_if.sink                          pass,
    dagac_result_if.source                      result,
    input  logic                                cfg_wr_en,
    input  logic [dagac_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dagac_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Configuration registers.
    logic [11:0] gas_high_reg;
    logic [11:0] gas_low_reg;
    logic [3:0]  wrong_limit_reg;
    logic [15:0] wrong_ms_reg;
    logic [19:0] close_delay_reg;

    // Pipeline registers.
    logic               pass_valid_reg;
    dagac_pkg::pass_t   pass_reg;
    logic               result_valid_reg;
    dagac_pkg::result_t result_reg;
    logic               advance;

    // Controller state and next values.
    logic        door_state_reg,    door_state_next;
    logic [3:0]  miss_count_reg,    miss_count_next;
    logic        wrong_alarm_reg,   wrong_alarm_next;
    logic [31:0] wrong_start_reg,   wrong_start_next;
    logic        gas_alarm_reg,     gas_alarm_next;
    logic        close_pending_reg, close_pending_next;
    logic [31:0] close_due_reg,     close_due_next;
    logic        chirp_active_reg,  chirp_active_next;
    logic [31:0] chirp_start_reg,   chirp_start_next;
    logic        chirp_double_reg,  chirp_double_next;
    dagac_pkg::result_t result_next;

    // Temporaries of the update logic.
    logic        sync;
    logic        sounding;
    logic        real_alarm;
    logic [31:0] wrong_elapsed;
    logic [31:0] chirp_elapsed;
    logic [31:0] close_diff;

    // Configuration write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gas_high_reg    <= dagac_pkg::GAS_HIGH_RST;
            gas_low_reg     <= dagac_pkg::GAS_LOW_RST;
            wrong_limit_reg <= dagac_pkg::WRONG_LIMIT_RST;
            wrong_ms_reg    <= dagac_pkg::WRONG_MS_RST;
            close_delay_reg <= dagac_pkg::CLOSE_DELAY_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                dagac_pkg::REG_GAS_HIGH:    gas_high_reg    <= cfg_data[11:0];
                dagac_pkg::REG_GAS_LOW:     gas_low_reg     <= cfg_data[11:0];
                dagac_pkg::REG_WRONG_LIMIT: wrong_limit_reg <= cfg_data[3:0];
                dagac_pkg::REG_WRONG_MS:    wrong_ms_reg    <= cfg_data[15:0];
                dagac_pkg::REG_CLOSE_DELAY: close_delay_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // The pass in the input register moves on when the result slot is free or its word is taken.
    assign advance     = pass_valid_reg && (!result_valid_reg || result.ready);
    assign pass.ready  = !pass_valid_reg || advance;
    assign result.valid = result_valid_reg;
    assign result.data  = result_reg;

    // Pipeline control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (pass.ready)
            begin
                pass_valid_reg <= pass.valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge clk)
    begin
        if (pass.ready && pass.valid)
        begin
            pass_reg <= pass.data;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // One control pass: card, alarm expiry, button, app, gas, auto-close, chirp, outputs.
    always_comb
    begin
        door_state_next    = door_state_reg;
        miss_count_next    = miss_count_reg;
        wrong_alarm_next   = wrong_alarm_reg;
        wrong_start_next   = wrong_start_reg;
        gas_alarm_next     = gas_alarm_reg;
        close_pending_next = close_pending_reg;
        close_due_next     = close_due_reg;
        chirp_active_next  = chirp_active_reg;
        chirp_start_next   = chirp_start_reg;
        chirp_double_next  = chirp_double_reg;
        sync               = 1'b0;
        sounding           = 1'b0;

        // Card scan.
        if (pass_reg.card_event)
        begin
            chirp_active_next = 1'b1;
            chirp_start_next  = pass_reg.now_ms;
            if (pass_reg.card_ok)
            begin
                door_state_next    = 1'b1;
                sync               = 1'b1;
                close_pending_next = 1'b0;
                miss_count_next    = 4'd0;
                chirp_double_next  = 1'b0;
            end
            else
            begin
                chirp_double_next = 1'b1;
                if (miss_count_reg != dagac_pkg::MISS_MAX)
                begin
                    miss_count_next = miss_count_reg + 4'd1;
                end
                if (miss_count_next >= wrong_limit_reg)
                begin
                    wrong_alarm_next = 1'b1;
                    wrong_start_next = pass_reg.now_ms;
                    miss_count_next  = 4'd0;
                end
            end
        end

        // Wrong-card alarm expiry.
        wrong_elapsed = pass_reg.now_ms - wrong_start_next;
        if (wrong_alarm_next && (wrong_elapsed >= {16'd0, wrong_ms_reg}))
        begin
            wrong_alarm_next = 1'b0;
        end

        // Door button toggles the door.
        if (pass_reg.door_button)
        begin
            door_state_next    = !door_state_next;
            sync               = 1'b1;
            close_pending_next = 1'b0;
        end

        // App command sets the door.
        if ((pass_reg.app_door == dagac_pkg::APP_CLOSE) ||
            (pass_reg.app_door == dagac_pkg::APP_OPEN))
        begin
            door_state_next    = (pass_reg.app_door == dagac_pkg::APP_OPEN);
            sync               = 1'b1;
            close_pending_next = 1'b0;
        end

        // Gas alarm with hysteresis.
        if (!gas_alarm_reg && (pass_reg.gas_level > gas_high_reg))
        begin
            gas_alarm_next     = 1'b1;
            close_pending_next = 1'b0;
            door_state_next    = 1'b1;
        end
        else if (gas_alarm_reg && (pass_reg.gas_level < gas_low_reg))
        begin
            gas_alarm_next     = 1'b0;
            close_pending_next = 1'b1;
            close_due_next     = pass_reg.now_ms + {12'd0, close_delay_reg};
        end

        // Wrap-safe auto-close.
        close_diff = pass_reg.now_ms - close_due_next;
        if (close_pending_next && !close_diff[31])
        begin
            close_pending_next = 1'b0;
            door_state_next    = 1'b0;
        end

        // Chirp pattern; a finished chirp is retired here.
        chirp_elapsed = pass_reg.now_ms - chirp_start_next;
        if (chirp_active_next)
        begin
            if (chirp_double_next)
            begin
                if (chirp_elapsed >= dagac_pkg::CHIRP_DOUBLE_MS)
                begin
                    chirp_active_next = 1'b0;
                end
                else
                begin
                    sounding = (chirp_elapsed < dagac_pkg::CHIRP_ON_MS) ||
                        ((chirp_elapsed >= dagac_pkg::CHIRP_PERIOD_MS) &&
                         (chirp_elapsed < (dagac_pkg::CHIRP_PERIOD_MS +
                                           dagac_pkg::CHIRP_ON_MS)));
                end
            end
            else
            begin
                if (chirp_elapsed >= dagac_pkg::CHIRP_SINGLE_MS)
                begin
                    chirp_active_next = 1'b0;
                end
                else
                begin
                    sounding = 1'b1;
                end
            end
        end

        // Output word.
        real_alarm                = gas_alarm_next || wrong_alarm_next;
        result_next.door_open     = door_state_next;
        result_next.door_sync     = sync;
        result_next.buzzer_on     = sounding || real_alarm;
        result_next.alert_led_on  = real_alarm;
        result_next.wrong_card_on = wrong_alarm_next;
        result_next.gas_alarm_on  = gas_alarm_next;
    end

    // Controller state commits with each result word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            door_state_reg    <= 1'b0;
            miss_count_reg    <= 4'd0;
            wrong_alarm_reg   <= 1'b0;
            wrong_start_reg   <= 32'd0;
            gas_alarm_reg     <= 1'b0;
            close_pending_reg <= 1'b0;
            close_due_reg     <= 32'd0;
            chirp_active_reg  <= 1'b0;
            chirp_start_reg   <= 32'd0;
            chirp_double_reg  <= 1'b0;
        end
        else if (advance)
        begin
            door_state_reg    <= door_state_next;
            miss_count_reg    <= miss_count_next;
            wrong_alarm_reg   <= wrong_alarm_next;
            wrong_start_reg   <= wrong_start_next;
            gas_alarm_reg     <= gas_alarm_next;
            close_pending_reg <= close_pending_next;
            close_due_reg     <= close_due_next;
            chirp_active_reg  <= chirp_active_next;
            chirp_start_reg   <= chirp_start_next;
            chirp_double_reg  <= chirp_double_next;
        end
    end

endmodule
